/* hdl/qxmm_pkg.sv */
// ----------------------------------------------------------------------------
// qxmm_pkg
// shared constants and types for the quad x motor mixer
// ----------------------------------------------------------------------------
`default_nettype none

package qxmm_pkg;

    // configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_YAW_LIMIT      = 3'd0;
    localparam t_cfg_index CFG_MIN_RUN_OUTPUT = 3'd1;
    localparam t_cfg_index CFG_MAX_OUTPUT     = 3'd2;
    localparam t_cfg_index CFG_SMOOTHING      = 3'd3;

    // register reset values
    localparam logic [11:0] RST_YAW_LIMIT  = 12'd400;
    localparam logic [11:0] RST_MIN_RUN    = 12'd100;
    localparam logic [11:0] RST_MAX_OUTPUT = 12'd1000;

    // mix clamp and throttle weight saturation
    localparam logic signed [18:0] MIX_LIMIT  = 19'sd1000;
    localparam logic [9:0]         MAG_LIMIT  = 10'd1000;
    localparam logic [15:0]        WEIGHT_ONE = 16'd32768;

    // expo curve: c = floor(mag*(11000 + 9*mag) * 2048 / 625)
    localparam logic [14:0] CURVE_BASE  = 15'd11000;
    localparam logic [14:0] CURVE_SLOPE = 15'd9;
    localparam logic [9:0]  CURVE_DIV   = 10'd625;

    // reciprocals of 625: quotient of a 25-bit value and of a 21-bit value
    localparam logic [25:0] RECIP_Q = 26'd54975582;  // ceil(2^35 / 625)
    localparam logic [25:0] RECIP_F = 26'd3435974;   // ceil(2^31 / 625)

    // saturation of the stored previous motor values
    localparam logic signed [19:0] PREV_MAX = 20'sd131071;
    localparam logic signed [19:0] PREV_MIN = -20'sd131072;

    // width of the shared multiplier operands
    localparam int MUL_W = 26;

endpackage

`default_nettype wire

/* hdl/quad_x_motor_mixer.sv */
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// four-motor x frame mixer with expo curve, throttle weight, smoothing and
// arming limits, worked through one shared multiplier motor by motor
// ----------------------------------------------------------------------------
// the result is loaded into the output register after the fourth motor is limited
// sequencing: nine sequencer steps per motor on the
//   single shared 26x26 multiplier, then one step to hand over the result
// the next item is taken while the finished result still waits downstream
// reset (synchronous, active low): registers to defaults, stored motor
//   history to zero, sequencer idle, no result pending
`default_nettype none

module quad_x_motor_mixer
    import qxmm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire t_cfg_index         i_cfg_index,
    input  wire logic [11:0]        i_cfg_data,
    // input item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_roll_cmd,
    input  wire logic signed [15:0] i_pitch_cmd,
    input  wire logic signed [15:0] i_yaw_cmd,
    input  wire logic [11:0]        i_throttle_value,
    input  wire logic [15:0]        i_throttle_weight,
    input  wire logic               i_throttle_low,
    input  wire logic               i_armed,
    // result item channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [11:0]             o_motor_0,
    output logic [11:0]             o_motor_1,
    output logic [11:0]             o_motor_2,
    output logic [11:0]             o_motor_3
);

    // sequencer codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MIX    = 4'd1;
    localparam logic [3:0] ST_MK     = 4'd2;
    localparam logic [3:0] ST_MQ     = 4'd3;
    localparam logic [3:0] ST_REM    = 4'd4;
    localparam logic [3:0] ST_MC2    = 4'd5;
    localparam logic [3:0] ST_MW     = 4'd6;
    localparam logic [3:0] ST_SUM    = 4'd7;
    localparam logic [3:0] ST_SMOOTH = 4'd8;
    localparam logic [3:0] ST_LIM    = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [3:0]  r_state, n_state;

    // configuration registers
    logic [11:0] r_yaw_limit;
    logic [11:0] r_min_run;
    logic [11:0] r_max_out;
    logic        r_smooth_en;

    // captured item
    logic signed [15:0] r_roll;
    logic signed [15:0] r_pitch;
    logic signed [12:0] r_yaw;
    logic [11:0]        r_thr;
    logic [15:0]        r_weight;
    logic               r_low;
    logic               r_armed;

    // per-motor working registers
    logic [1:0]             r_idx;
    logic [9:0]             r_mag;
    logic                   r_neg;
    logic [2*MUL_W-1:0]     r_prod;
    logic [24:0]            r_k;
    logic [14:0]            r_q;
    logic [9:0]             r_rem;
    logic signed [35:0]     r_v;
    logic signed [17:0]     r_prev [4];
    logic [11:0]            r_motor [4];

    // result register
    logic        r_out_valid;
    logic [11:0] r_out [4];

    logic w_in_acc;
    logic w_load;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_load      = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // yaw clamp and weight saturation on the incoming item
    logic signed [16:0] w_yaw17, w_ylim17;
    logic signed [12:0] w_yaw_cl;
    logic [15:0]        w_weight_sat;

    always_comb begin
        w_yaw17  = {i_yaw_cmd[15], i_yaw_cmd};
        w_ylim17 = $signed({5'b0, r_yaw_limit});
        if (w_yaw17 > w_ylim17) begin
            w_yaw_cl = w_ylim17[12:0];
        end else if (w_yaw17 < -w_ylim17) begin
            w_yaw_cl = 13'(-w_ylim17);
        end else begin
            w_yaw_cl = w_yaw17[12:0];
        end
        w_weight_sat = (i_throttle_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_throttle_weight;
    end

    // x mix for the current motor, clamped to the mix limit
    logic signed [18:0] w_r19, w_p19, w_y19, w_mix;
    logic [9:0]         w_mag;
    logic               w_neg;

    always_comb begin
        w_r19 = {{3{r_roll[15]}}, r_roll};
        w_p19 = {{3{r_pitch[15]}}, r_pitch};
        w_y19 = {{6{r_yaw[12]}}, r_yaw};
        w_mix = ((r_idx[0] ^ r_idx[1]) ? w_r19 : -w_r19)
              + (r_idx[1] ? -w_p19 : w_p19)
              + (r_idx[0] ? -w_y19 : w_y19);
        if (w_mix > MIX_LIMIT) begin
            w_mag = MAG_LIMIT;
            w_neg = 1'b0;
        end else if (w_mix < -MIX_LIMIT) begin
            w_mag = MAG_LIMIT;
            w_neg = 1'b1;
        end else begin
            w_mag = w_mix[18] ? 10'(-w_mix) : w_mix[9:0];
            w_neg = w_mix[18];
        end
    end

    // shared multiplier operand selection
    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [2*MUL_W-1:0] w_mul_p;
    logic [14:0]        w_curve_b;
    logic [10:0]        w_frac;
    logic [25:0]        w_curve;

    always_comb begin
        w_curve_b = CURVE_BASE + 15'(r_mag) * CURVE_SLOPE;
        w_frac    = r_prod[41:31];
        w_curve   = {r_q, w_frac};
        case (r_state)
            ST_MK: begin
                w_mul_a = MUL_W'(r_mag);
                w_mul_b = MUL_W'(w_curve_b);
            end
            ST_MQ: begin
                w_mul_a = MUL_W'(r_prod[24:0]);
                w_mul_b = RECIP_Q;
            end
            ST_MC2: begin
                w_mul_a = MUL_W'({r_rem, 11'b0});
                w_mul_b = RECIP_F;
            end
            ST_MW: begin
                w_mul_a = w_curve;
                w_mul_b = MUL_W'(r_weight);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    // remainder of the curve quotient
    logic [24:0] w_rem25;
    assign w_rem25 = r_k - 25'(r_prod[49:35]) * 25'(CURVE_DIV);

    // weighted curve added to the throttle, in q16
    logic signed [35:0] w_wc, w_base, w_sum_v;
    always_comb begin
        w_wc    = $signed({9'b0, r_prod[41:15]});
        w_base  = $signed({8'b0, r_thr, 16'b0});
        w_sum_v = r_neg ? (w_base - w_wc) : (w_base + w_wc);
    end

    // smoothing against the stored value of this motor
    logic signed [35:0] w_old, w_hsum, w_smooth, w_adj;
    logic signed [19:0] w_prev_t;
    logic signed [17:0] w_prev_sat;

    always_comb begin
        w_old = {{2{r_prev[r_idx][17]}}, r_prev[r_idx], 16'b0};
        w_hsum = w_old + r_v;
        if (r_v > w_old) begin
            w_smooth = (w_hsum + $signed({35'b0, w_hsum[35]})) >>> 1;
        end else begin
            w_smooth = (r_v <<< 1) - w_old;
        end
        w_adj    = w_smooth + $signed({20'b0, {16{w_smooth[35]}}});
        w_prev_t = w_adj[35:16];
        if (w_prev_t > PREV_MAX) begin
            w_prev_sat = PREV_MAX[17:0];
        end else if (w_prev_t < PREV_MIN) begin
            w_prev_sat = PREV_MIN[17:0];
        end else begin
            w_prev_sat = w_prev_t[17:0];
        end
    end

    // output limits by arming and low throttle
    logic signed [35:0] w_lo, w_hi;
    logic [11:0]        w_lim;

    always_comb begin
        w_lo = r_low ? 36'sd0 : $signed({8'b0, r_min_run, 16'b0});
        w_hi = $signed({8'b0, r_max_out, 16'b0});
        if (!r_armed) begin
            w_lim = '0;
        end else if (r_v < w_lo) begin
            w_lim = r_low ? 12'd0 : r_min_run;
        end else if (r_v > w_hi) begin
            w_lim = r_max_out;
        end else begin
            w_lim = r_v[27:16];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_in_acc) n_state = ST_MIX;
            ST_MIX:    n_state = ST_MK;
            ST_MK:     n_state = ST_MQ;
            ST_MQ:     n_state = ST_REM;
            ST_REM:    n_state = ST_MC2;
            ST_MC2:    n_state = ST_MW;
            ST_MW:     n_state = ST_SUM;
            ST_SUM:    n_state = ST_SMOOTH;
            ST_SMOOTH: n_state = ST_LIM;
            ST_LIM:    n_state = (r_idx == 2'd3) ? ST_DONE : ST_MIX;
            ST_DONE:   if (w_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state, configuration and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_yaw_limit <= RST_YAW_LIMIT;
            r_min_run   <= RST_MIN_RUN;
            r_max_out   <= RST_MAX_OUTPUT;
            r_smooth_en <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_idx <= '0;
            end else if (r_state == ST_LIM) begin
                r_idx <= r_idx + 2'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_YAW_LIMIT:      r_yaw_limit <= i_cfg_data;
                    CFG_MIN_RUN_OUTPUT: r_min_run   <= i_cfg_data;
                    CFG_MAX_OUTPUT:     r_max_out   <= i_cfg_data;
                    CFG_SMOOTHING:      r_smooth_en <= i_cfg_data[0];
                    default:            ;
                endcase
            end
            if (r_state == ST_SMOOTH && r_smooth_en) begin
                r_prev[r_idx] <= w_prev_sat;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        if (w_in_acc) begin
            r_roll   <= i_roll_cmd;
            r_pitch  <= i_pitch_cmd;
            r_yaw    <= w_yaw_cl;
            r_thr    <= i_throttle_value;
            r_weight <= w_weight_sat;
            r_low    <= i_throttle_low;
            r_armed  <= i_armed;
        end
        case (r_state)
            ST_MIX: begin
                r_mag <= w_mag;
                r_neg <= w_neg;
            end
            ST_MQ:  r_k <= r_prod[24:0];
            ST_REM: begin
                r_q   <= r_prod[49:35];
                r_rem <= w_rem25[9:0];
            end
            ST_SUM: r_v <= w_sum_v;
            ST_SMOOTH: begin
                if (r_smooth_en) begin
                    r_v <= w_smooth;
                end
            end
            ST_LIM: r_motor[r_idx] <= w_lim;
            default: ;
        endcase
        if (w_load) begin
            for (int i = 0; i < 4; i++) begin
                r_out[i] <= r_motor[i];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_motor_0   = r_out[0];
    assign o_motor_1   = r_out[1];
    assign o_motor_2   = r_out[2];
    assign o_motor_3   = r_out[3];

    // checks on the sequencer and datapath
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_MIX) && (r_idx == 2'd0))
        else $error("accepted item did not start motor zero");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid && (r_state == ST_IDLE))
        else $error("finished item not presented");

    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MK) |-> (r_mag <= MAG_LIMIT))
        else $error("mix magnitude above limit");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MC2) |-> (r_rem < CURVE_DIV))
        else $error("curve remainder out of range");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIM && r_idx != 2'd3) |=> o_in_stall && (r_state == ST_MIX))
        else $error("sequencer left a motor unfinished");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quad x motor mixer: a scoreboard keeps its own
// copy of the registers and the motor history, predicts the four motor values
// of every accepted item and checks each result item as it leaves the block,
// over directed corner items and random phases with varied settings and idling
// ----------------------------------------------------------------------------

module tb;
    import qxmm_pkg::*;

    // arithmetic constants of the mixer, q16 internally
    localparam longint Q16       = 65536;
    localparam longint MIX_CLAMP = 1000;
    localparam longint W_ONE     = 32768;
    localparam longint HIST_MAX  = 131071;
    localparam longint HIST_MIN  = -131072;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 125;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic [11:0]        thr;
        logic [15:0]        weight;
        logic               low;
        logic               armed;
    } t_cmd_item;

    typedef logic [3:0][11:0] t_motor_set;

    // expected motor values and the mixer state behind them
    class mix_scoreboard;
        logic [11:0] yaw_lim;
        logic [11:0] min_run;
        logic [11:0] max_out;
        logic        smooth_on;
        longint      hist[4];
        t_motor_set  motor_q[$];
        int          n_fail;

        function new();
            yaw_lim   = RST_YAW_LIMIT;
            min_run   = RST_MIN_RUN;
            max_out   = RST_MAX_OUTPUT;
            smooth_on = 1'b0;
            foreach (hist[i]) hist[i] = 0;
            n_fail    = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [11:0] data);
            case (idx)
                CFG_YAW_LIMIT:      yaw_lim = data;
                CFG_MIN_RUN_OUTPUT: min_run = data;
                CFG_MAX_OUTPUT:     max_out = data;
                CFG_SMOOTHING:      smooth_on = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return motor_q.size();
        endfunction

        // mix, expo, weight, smoothing and limits for one item
        function void note_input(t_cmd_item it);
            longint     r, p, y, thr, w, m, mag, c, wc, v, old, lo, hi;
            longint     mix[4];
            t_motor_set res;
            r   = longint'(it.roll);
            p   = longint'(it.pitch);
            y   = longint'(it.yaw);
            thr = longint'(it.thr);
            w   = longint'(it.weight);
            if (w > W_ONE) w = W_ONE;
            if (y > longint'(yaw_lim)) y = longint'(yaw_lim);
            if (y < -longint'(yaw_lim)) y = -longint'(yaw_lim);
            mix[0] = -r + p + y;
            mix[1] =  r + p - y;
            mix[2] =  r - p + y;
            mix[3] = -r - p - y;
            for (int i = 0; i < 4; i++) begin
                m = mix[i];
                if (m > MIX_CLAMP) m = MIX_CLAMP;
                if (m < -MIX_CLAMP) m = -MIX_CLAMP;
                mag = (m < 0) ? -m : m;
                c   = (mag * (550000 + 450 * mag) * Q16) / 1000000;
                wc  = (c * w) / W_ONE;
                if (m < 0) wc = -wc;
                v = thr * Q16 + wc;
                // rise takes the mean, fall overshoots
                if (smooth_on) begin
                    old = hist[i] * Q16;
                    if (v > old) v = (old + v) / 2;
                    else v = 2 * v - old;
                    hist[i] = v / Q16;
                    if (hist[i] > HIST_MAX) hist[i] = HIST_MAX;
                    if (hist[i] < HIST_MIN) hist[i] = HIST_MIN;
                end
                // when the bounds cross, a value under the lower bound takes it, any other the upper
                if (!it.armed) begin
                    v = 0;
                end else begin
                    lo = it.low ? 0 : longint'(min_run) * Q16;
                    hi = longint'(max_out) * Q16;
                    if (v < lo) v = lo;
                    else if (v > hi) v = hi;
                end
                res[i] = 12'(v / Q16);
            end
            motor_q.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            n_fail++;
        endtask

        task check_result(t_motor_set got);
            t_motor_set exp_set;
            if (motor_q.size() == 0) begin
                report($sformatf("result item with nothing expected, motors %0d %0d %0d %0d",
                                 got[0], got[1], got[2], got[3]));
            end else begin
                exp_set = motor_q.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== exp_set[i])
                        report($sformatf("motor_%0d got %0d expected %0d",
                                         i, got[i], exp_set[i]));
                end
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_index         i_cfg_index;
    logic [11:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_roll_cmd;
    logic signed [15:0] i_pitch_cmd;
    logic signed [15:0] i_yaw_cmd;
    logic [11:0]        i_throttle_value;
    logic [15:0]        i_throttle_weight;
    logic               i_throttle_low;
    logic               i_armed;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [11:0]        o_motor_0;
    logic [11:0]        o_motor_1;
    logic [11:0]        o_motor_2;
    logic [11:0]        o_motor_3;

    mix_scoreboard sb;
    logic          live = 1'b0;
    int            in_idle_pct = 0;
    int            out_stall_pct = 0;

    quad_x_motor_mixer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_roll_cmd        (i_roll_cmd),
        .i_pitch_cmd       (i_pitch_cmd),
        .i_yaw_cmd         (i_yaw_cmd),
        .i_throttle_value  (i_throttle_value),
        .i_throttle_weight (i_throttle_weight),
        .i_throttle_low    (i_throttle_low),
        .i_armed           (i_armed),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_motor_0         (o_motor_0),
        .o_motor_1         (o_motor_1),
        .o_motor_2         (o_motor_2),
        .o_motor_3         (o_motor_3)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: check accepted items, stall at random
    always @(posedge i_clk) begin
        if (live && o_out_valid && !i_out_stall)
            sb.check_result({o_motor_3, o_motor_2, o_motor_1, o_motor_0});
        i_out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
    end

    function automatic t_cmd_item make_cmd(int r, int p, int y, int thr, int w,
                                           bit low, bit armed);
        t_cmd_item it;
        it.roll   = 16'(r);
        it.pitch  = 16'(p);
        it.yaw    = 16'(y);
        it.thr    = 12'(thr);
        it.weight = 16'(w);
        it.low    = low;
        it.armed  = armed;
        return it;
    endfunction

    // mostly near the mix clamp, some tiny, some anywhere in range
    function automatic logic signed [15:0] pick_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65) return 16'(int'($urandom_range(2400)) - 1200);
        if (sel < 85) return 16'(int'($urandom_range(100)) - 50);
        return 16'($urandom);
    endfunction

    function automatic t_cmd_item pick_item();
        t_cmd_item it;
        int        sel;
        it.roll  = pick_cmd();
        it.pitch = pick_cmd();
        it.yaw   = pick_cmd();
        sel = $urandom_range(99);
        if (sel < 55) it.thr = 12'($urandom_range(1200));
        else if (sel < 90) it.thr = 12'($urandom_range(4095));
        else it.thr = $urandom_range(1) ? 12'd4095 : 12'd0;
        sel = $urandom_range(99);
        if (sel < 70) it.weight = 16'($urandom_range(32768));
        else if (sel < 85) it.weight = 16'(32767 + $urandom_range(2));
        else it.weight = 16'($urandom);
        it.low   = ($urandom_range(99) < 25);
        it.armed = ($urandom_range(99) < 88);
        return it;
    endfunction

    // one input item, with random idle cycles ahead of it
    task automatic send_item(t_cmd_item it);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid        <= 1'b1;
        i_roll_cmd        <= it.roll;
        i_pitch_cmd       <= it.pitch;
        i_yaw_cmd         <= it.yaw;
        i_throttle_value  <= it.thr;
        i_throttle_weight <= it.weight;
        i_throttle_low    <= it.low;
        i_armed           <= it.armed;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // valid is left high, the caller lowers it after the last write
    task automatic write_cfg(t_cfg_index idx, logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // settings per phase: extremes first, random after
    task automatic set_phase_cfg(int ph);
        logic [11:0] yaw, mn, mx;
        logic        sm;
        case (ph)
            1: begin yaw = 12'd0;    mn = 12'd0;    mx = 12'd4095; sm = 1'b1; end
            2: begin yaw = 12'd4095; mn = 12'd4095; mx = 12'd4095; sm = 1'b1; end
            3: begin yaw = 12'd2000; mn = 12'd3000; mx = 12'd500;  sm = 1'b0; end
            4: begin yaw = 12'd0;    mn = 12'd100;  mx = 12'd4095; sm = 1'b1; end
            5: begin yaw = 12'd1200; mn = 12'd0;    mx = 12'd0;    sm = 1'b1; end
            6: begin
                yaw = RST_YAW_LIMIT; mn = RST_MIN_RUN; mx = RST_MAX_OUTPUT; sm = 1'b0;
            end
            default: begin
                yaw = 12'($urandom_range(1500));
                mn  = 12'($urandom_range(600));
                mx  = 12'($urandom_range(400, 4095));
                sm  = 1'($urandom_range(1));
            end
        endcase
        write_cfg(CFG_SMOOTHING, {11'($urandom), sm});
        write_cfg(CFG_YAW_LIMIT, yaw);
        write_cfg(CFG_MIN_RUN_OUTPUT, mn);
        // unused index, must leave every register alone
        write_cfg(t_cfg_index'(CFG_SMOOTHING + $urandom_range(1, 4)), 12'($urandom));
        write_cfg(CFG_MAX_OUTPUT, mx);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_cmd_item dir_q[$];
        int        mode;
        sb = new();
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= CFG_YAW_LIMIT;
        i_cfg_data        <= 12'd0;
        i_in_valid        <= 1'b0;
        i_roll_cmd        <= 16'sd0;
        i_pitch_cmd       <= 16'sd0;
        i_yaw_cmd         <= 16'sd0;
        i_throttle_value  <= 12'd0;
        i_throttle_weight <= 16'd0;
        i_throttle_low    <= 1'b0;
        i_armed           <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        live    <= 1'b1;
        @(posedge i_clk);

        // corner items under reset settings
        dir_q.push_back(make_cmd(0, 0, 0, 0, 32768, 0, 1));
        dir_q.push_back(make_cmd(0, 0, 0, 0, 32768, 1, 1));
        dir_q.push_back(make_cmd(300, -200, 100, 4095, 32768, 0, 0));
        dir_q.push_back(make_cmd(32767, 0, 0, 2000, 32768, 0, 1));
        dir_q.push_back(make_cmd(-32768, 0, 0, 2000, 32768, 0, 1));
        dir_q.push_back(make_cmd(0, 32767, 0, 2000, 32768, 0, 1));
        dir_q.push_back(make_cmd(0, -32768, 0, 2000, 32768, 0, 1));
        dir_q.push_back(make_cmd(0, 0, 32767, 500, 32768, 0, 1));
        dir_q.push_back(make_cmd(0, 0, -32768, 500, 32768, 0, 1));
        dir_q.push_back(make_cmd(1000, 0, 0, 800, 32768, 0, 1));
        dir_q.push_back(make_cmd(1001, 0, 0, 800, 32768, 0, 1));
        dir_q.push_back(make_cmd(-1000, 0, 0, 800, 32768, 0, 1));
        dir_q.push_back(make_cmd(-1001, 0, 0, 800, 32768, 0, 1));
        dir_q.push_back(make_cmd(600, 0, 0, 1500, 65535, 0, 1));
        dir_q.push_back(make_cmd(600, 0, 0, 1500, 32769, 0, 1));
        dir_q.push_back(make_cmd(600, 0, 0, 1500, 0, 0, 1));
        dir_q.push_back(make_cmd(0, 0, 0, 4095, 32768, 0, 1));
        dir_q.push_back(make_cmd(-32768, -32768, -32768, 4095, 65535, 1, 1));
        dir_q.push_back(make_cmd(32767, 32767, 32767, 4095, 65535, 1, 1));
        dir_q.push_back(make_cmd(250, 400, -399, 600, 20000, 0, 1));
        dir_q.push_back(make_cmd(1, -1, 401, 100, 1, 1, 1));
        dir_q.push_back(make_cmd(-21846, 21845, 0, 2730, 43690, 0, 1));
        foreach (dir_q[i]) send_item(dir_q[i]);

        // random phases: idle none, sender, receiver, both
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                set_phase_cfg(ph);
            end
            mode = ph % 4;
            in_idle_pct   = (mode == 1) ? 84 : (mode == 3) ? 14 : 0;
            out_stall_pct = (mode == 2) ? 84 : (mode == 3) ? 14 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sender holds off until the pipe is empty
                if (ph % 3 == 1 && k == PHASE_ITEMS / 2) wait_drained();
                send_item(pick_item());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d result items never arrived", sb.pending()));
        if (sb.n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
